// ===== hw/rtl/fmmb_pkg.sv =====
// Shared types and constants for the four-muon mass band filter.
// Holds the request and result payloads, the kept-muon record and register codes.
// No dependencies.
`default_nettype none

package fmmb_pkg;

    localparam int MOM_W      = 24;
    localparam int EN_W       = 23;
    localparam int KEEP_COUNT = 4;
    localparam int SQ_W       = 2 * MOM_W - 1;
    localparam int PT_W       = 2 * MOM_W;
    localparam int HALF_W     = PT_W / 2;
    localparam int ETA_W      = 24;
    localparam int ETA_FRAC   = 8;
    localparam int RHS_W      = PT_W + ETA_W;
    localparam int SUM_W      = MOM_W + 2;
    localparam int ESUM_W     = EN_W + 2;
    localparam int MASS_W     = 2 * SUM_W + 1;
    localparam int PROB_W     = 17;
    localparam int RAND_W     = 16;
    localparam int CNT_W      = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef enum logic [2:0] {
        REG_MIN_PT       = 3'd0,
        REG_ETA_LIMIT_SQ = 3'd1,
        REG_MASS_LOW     = 3'd2,
        REG_MASS_HIGH    = 3'd3,
        REG_PROB_LOW     = 3'd4,
        REG_PROB_MID     = 3'd5,
        REG_PROB_HIGH    = 3'd6,
        REG_REWEIGHT_EN  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } band_t;

    typedef struct packed {
        logic                    particle_valid;
        logic                    is_muon;
        logic                    is_stable;
        logic signed [MOM_W-1:0] mom_x;
        logic signed [MOM_W-1:0] mom_y;
        logic signed [MOM_W-1:0] mom_z;
        logic [EN_W-1:0]         energy;
        logic                    last_particle;
        logic [RAND_W-1:0]       random_draw;
    } item_t;

    typedef struct packed {
        logic             event_passed;
        logic             enough_muons;
        band_t            mass_band;
        logic [CNT_W-1:0] muon_count;
    } result_t;

    typedef struct packed {
        logic signed [MOM_W-1:0] px;
        logic signed [MOM_W-1:0] py;
        logic signed [MOM_W-1:0] pz;
        logic [EN_W-1:0]         energy;
        logic [PT_W-1:0]         pt2;
    } muon_t;

    typedef struct packed {
        logic valid;
        logic ins;
    } link_t;

    typedef struct packed {
        logic ins;
        logic clr;
    } chain_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fmmb_cell.sv =====
// One slot of the sorted top-four muon chain.
// Takes the candidate, shifts in from its left neighbor, holds, or is cleared.
// Depends on fmmb_pkg.
`default_nettype none

module fmmb_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fmmb_pkg::chain_ctl_t    ctl,
    input  wire fmmb_pkg::muon_t         cand,
    input  wire fmmb_pkg::muon_t         left_muon,
    input  wire fmmb_pkg::link_t         left_link,
    output fmmb_pkg::muon_t              held,
    output fmmb_pkg::link_t              link
);
    import fmmb_pkg::*;

    muon_t data_reg;
    muon_t data_next;
    logic  valid_reg;
    logic  valid_next;
    logic  ins;

    assign ins  = !valid_reg || (cand.pt2 > data_reg.pt2);
    assign held = data_reg;
    assign link = '{valid: valid_reg, ins: ins};

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            priority if (left_link.ins)
            begin
                data_next  = left_muon;
                valid_next = left_link.valid;
            end
            else if (ins)
            begin
                data_next  = cand;
                valid_next = 1'b1;
            end
            else
            begin
                data_next  = data_reg;
            end
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fmmb_chain.sv =====
// Row of kept-muon cells in descending pt order, plus the four-vector sums.
// Depends on fmmb_pkg and fmmb_cell.
`default_nettype none

module fmmb_chain (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fmmb_pkg::chain_ctl_t            ctl,
    input  wire fmmb_pkg::muon_t                 cand,
    output logic signed [fmmb_pkg::SUM_W-1:0]    sum_x,
    output logic signed [fmmb_pkg::SUM_W-1:0]    sum_y,
    output logic signed [fmmb_pkg::SUM_W-1:0]    sum_z,
    output logic        [fmmb_pkg::ESUM_W-1:0]   sum_e
);
    import fmmb_pkg::*;

    muon_t held [KEEP_COUNT];
    link_t link [KEEP_COUNT];
    muon_t left_muon [KEEP_COUNT];
    link_t left_link [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] valid_vec;

    assign left_muon[0] = '0;
    assign left_link[0] = '{valid: 1'b0, ins: 1'b0};

    for (genvar i = 0; i < KEEP_COUNT; i++)
    begin : g_cell
        if (i > 0)
        begin : g_link
            assign left_muon[i] = held[i-1];
            assign left_link[i] = link[i-1];
        end
        assign valid_vec[i] = link[i].valid;

        fmmb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cand      (cand),
            .left_muon (left_muon[i]),
            .left_link (left_link[i]),
            .held      (held[i]),
            .link      (link[i])
        );
    end

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        sum_e = '0;
        for (int i = 0; i < KEEP_COUNT; i++)
        begin
            sum_x = sum_x + SUM_W'(held[i].px);
            sum_y = sum_y + SUM_W'(held[i].py);
            sum_z = sum_z + SUM_W'(held[i].pz);
            sum_e = sum_e + ESUM_W'(held[i].energy);
        end
    end

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec == 4'b0000 || valid_vec == 4'b0001 || valid_vec == 4'b0011 ||
        valid_vec == 4'b0111 || valid_vec == 4'b1111)
        else $error("kept muons not packed at the head of the chain");

    for (genvar i = 1; i < KEEP_COUNT; i++)
    begin : g_order
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            valid_vec[i] |-> held[i-1].pt2 >= held[i].pt2)
            else $error("kept muons out of pt order");
    end

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |=> valid_vec == '0)
        else $error("chain not empty after event clear");

endmodule

`default_nettype wire

// ===== hw/rtl/top_four_muon_mass_band_filter.sv =====
// Four-muon mass band filter: muon selection, top-four chain, mass band and reweighting.
// A request that does not close its event passes the square, pt, eta, compare and insert
// states, then the block is ready again. A closing request goes on through the sum, mass
// square, momentum-sum, edge and band states; its result is registered once the output is
// free. The single sequencer takes no new request until it is idle again. Reset restores
// register defaults and empties the chain. Depends on fmmb_pkg and fmmb_chain.
`default_nettype none

module top_four_muon_mass_band_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fmmb_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [fmmb_pkg::DATA_W-1:0]     pwdata,
    output logic      [fmmb_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire fmmb_pkg::item_t                 item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output fmmb_pkg::result_t                    result
);
    import fmmb_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_SQ   = 11'b00000000010,
        ST_PT   = 11'b00000000100,
        ST_ETA  = 11'b00000001000,
        ST_CMP  = 11'b00000010000,
        ST_INS  = 11'b00000100000,
        ST_SUM  = 11'b00001000000,
        ST_MSQ  = 11'b00010000000,
        ST_PSUM = 11'b00100000000,
        ST_EDGE = 11'b01000000000,
        ST_BAND = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [EN_W-1:0]   min_pt_reg;
    logic [ETA_W-1:0]  eta_limit_sq_reg;
    logic [EN_W-1:0]   mass_low_reg;
    logic [EN_W-1:0]   mass_high_reg;
    logic [PROB_W-1:0] prob_low_reg;
    logic [PROB_W-1:0] prob_mid_reg;
    logic [PROB_W-1:0] prob_high_reg;
    logic              reweight_enable_reg;

    reg_idx_t cfg_idx;
    logic     cfg_write;

    item_t               item_reg;
    logic                sel_reg;
    logic [SQ_W-1:0]     px2_reg;
    logic [SQ_W-1:0]     py2_reg;
    logic [SQ_W-1:0]     pz2_reg;
    logic [2*EN_W-1:0]   min_pt_sq_reg;
    logic [PT_W-1:0]     pt2_reg;
    logic                pt_ok_reg;
    logic [PT_W-1:0]     rhs_lo_reg;
    logic [PT_W-1:0]     rhs_hi_reg;
    logic                qual_reg;
    logic [CNT_W-1:0]    count_reg;

    logic signed [PT_W-1:0] px_sq;
    logic signed [PT_W-1:0] py_sq;
    logic signed [PT_W-1:0] pz_sq;
    logic [RHS_W-1:0]       rhs;
    logic [RHS_W-1:0]       lhs;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [ESUM_W-1:0]       sum_e;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sy_reg;
    logic signed [SUM_W-1:0] sz_reg;
    logic [ESUM_W-1:0]       se_reg;

    logic signed [2*SUM_W-1:0] sx_sq;
    logic signed [2*SUM_W-1:0] sy_sq;
    logic signed [2*SUM_W-1:0] sz_sq;
    logic [2*SUM_W-1:0]        sx2_reg;
    logic [2*SUM_W-1:0]        sy2_reg;
    logic [2*SUM_W-1:0]        sz2_reg;
    logic [2*ESUM_W-1:0]       se2_reg;
    logic [2*EN_W-1:0]         ml2_reg;
    logic [2*EN_W-1:0]         mh2_reg;
    logic [MASS_W-1:0]         p2_reg;
    logic [MASS_W-1:0]         lo_edge_reg;
    logic [MASS_W-1:0]         hi_edge_reg;

    chain_ctl_t  ctl;
    muon_t       cand;
    logic        out_free;
    logic        enough;
    band_t       band;
    logic [PROB_W-1:0] prob;
    result_t     res_next;
    result_t     result_reg;
    logic        result_valid_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pt_reg          <= EN_W'(1000);
            eta_limit_sq_reg    <= ETA_W'(1409567);
            mass_low_reg        <= EN_W'(11000);
            mass_high_reg       <= EN_W'(25000);
            prob_low_reg        <= PROB_W'(65536);
            prob_mid_reg        <= PROB_W'(32768);
            prob_high_reg       <= PROB_W'(6554);
            reweight_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_MIN_PT:       min_pt_reg          <= pwdata[EN_W-1:0];
                REG_ETA_LIMIT_SQ: eta_limit_sq_reg    <= pwdata[ETA_W-1:0];
                REG_MASS_LOW:     mass_low_reg        <= pwdata[EN_W-1:0];
                REG_MASS_HIGH:    mass_high_reg       <= pwdata[EN_W-1:0];
                REG_PROB_LOW:     prob_low_reg        <= pwdata[PROB_W-1:0];
                REG_PROB_MID:     prob_mid_reg        <= pwdata[PROB_W-1:0];
                REG_PROB_HIGH:    prob_high_reg       <= pwdata[PROB_W-1:0];
                REG_REWEIGHT_EN:  reweight_enable_reg <= pwdata[0];
                default:          reweight_enable_reg <= reweight_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_PT:       prdata = DATA_W'(min_pt_reg);
            REG_ETA_LIMIT_SQ: prdata = DATA_W'(eta_limit_sq_reg);
            REG_MASS_LOW:     prdata = DATA_W'(mass_low_reg);
            REG_MASS_HIGH:    prdata = DATA_W'(mass_high_reg);
            REG_PROB_LOW:     prdata = DATA_W'(prob_low_reg);
            REG_PROB_MID:     prdata = DATA_W'(prob_mid_reg);
            REG_PROB_HIGH:    prdata = DATA_W'(prob_high_reg);
            REG_REWEIGHT_EN:  prdata = DATA_W'(reweight_enable_reg);
            default:          prdata = '0;
        endcase
    end

    // Sequencer
    assign item_ready = (state_reg == ST_IDLE);
    assign out_free   = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (item_valid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_PT;
            ST_PT:   state_next = ST_ETA;
            ST_ETA:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_INS;
            ST_INS:  state_next = item_reg.last_particle ? ST_SUM : ST_IDLE;
            ST_SUM:  state_next = ST_MSQ;
            ST_MSQ:  state_next = ST_PSUM;
            ST_PSUM: state_next = ST_EDGE;
            ST_EDGE: state_next = ST_BAND;
            ST_BAND: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Selection front end
    assign px_sq = item_reg.mom_x * item_reg.mom_x;
    assign py_sq = item_reg.mom_y * item_reg.mom_y;
    assign pz_sq = item_reg.mom_z * item_reg.mom_z;
    assign rhs   = (RHS_W'(rhs_hi_reg) << HALF_W) + RHS_W'(rhs_lo_reg);
    assign lhs   = RHS_W'({pz2_reg, ETA_FRAC'(0)});

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_SQ)
        begin
            px2_reg       <= px_sq[SQ_W-1:0];
            py2_reg       <= py_sq[SQ_W-1:0];
            pz2_reg       <= pz_sq[SQ_W-1:0];
            min_pt_sq_reg <= min_pt_reg * min_pt_reg;
            sel_reg       <= item_reg.particle_valid && item_reg.is_muon && item_reg.is_stable;
        end
        if (state_reg == ST_PT)
        begin
            pt2_reg <= PT_W'(px2_reg) + PT_W'(py2_reg);
        end
        if (state_reg == ST_ETA)
        begin
            rhs_lo_reg <= pt2_reg[HALF_W-1:0] * eta_limit_sq_reg;
            rhs_hi_reg <= pt2_reg[PT_W-1:HALF_W] * eta_limit_sq_reg;
            pt_ok_reg  <= pt2_reg >= PT_W'(min_pt_sq_reg);
        end
        if (state_reg == ST_CMP)
        begin
            qual_reg <= sel_reg && pt_ok_reg && (lhs <= rhs);
        end
    end

    // Top-four chain
    assign ctl.ins     = (state_reg == ST_INS) && qual_reg;
    assign ctl.clr     = (state_reg == ST_BAND) && out_free;
    assign cand.px     = item_reg.mom_x;
    assign cand.py     = item_reg.mom_y;
    assign cand.pz     = item_reg.mom_z;
    assign cand.energy = item_reg.energy;
    assign cand.pt2    = pt2_reg;

    fmmb_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cand  (cand),
        .sum_x (sum_x),
        .sum_y (sum_y),
        .sum_z (sum_z),
        .sum_e (sum_e)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.clr)
        begin
            count_reg <= '0;
        end
        else if (ctl.ins && count_reg != {CNT_W{1'b1}})
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Mass band
    assign sx_sq = sx_reg * sx_reg;
    assign sy_sq = sy_reg * sy_reg;
    assign sz_sq = sz_reg * sz_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
        begin
            sx_reg <= sum_x;
            sy_reg <= sum_y;
            sz_reg <= sum_z;
            se_reg <= sum_e;
        end
        if (state_reg == ST_MSQ)
        begin
            sx2_reg <= sx_sq;
            sy2_reg <= sy_sq;
            sz2_reg <= sz_sq;
            se2_reg <= se_reg * se_reg;
            ml2_reg <= mass_low_reg * mass_low_reg;
            mh2_reg <= mass_high_reg * mass_high_reg;
        end
        if (state_reg == ST_PSUM)
        begin
            p2_reg <= MASS_W'(sx2_reg) + MASS_W'(sy2_reg) + MASS_W'(sz2_reg);
        end
        if (state_reg == ST_EDGE)
        begin
            lo_edge_reg <= p2_reg + MASS_W'(ml2_reg);
            hi_edge_reg <= p2_reg + MASS_W'(mh2_reg);
        end
    end

    assign enough = count_reg >= CNT_W'(KEEP_COUNT);

    always_comb
    begin
        priority if (!enough)
            band = BAND_LOW;
        else if (MASS_W'(se2_reg) < lo_edge_reg)
            band = BAND_LOW;
        else if (MASS_W'(se2_reg) > hi_edge_reg)
            band = BAND_HIGH;
        else
            band = BAND_MID;

        unique case (band)
            BAND_LOW:  prob = prob_low_reg;
            BAND_MID:  prob = prob_mid_reg;
            BAND_HIGH: prob = prob_high_reg;
            default:   prob = '0;
        endcase

        res_next.enough_muons = enough;
        res_next.mass_band    = band;
        res_next.muon_count   = count_reg;
        res_next.event_passed = enough &&
            (!reweight_enable_reg || PROB_W'(item_reg.random_draw) < prob);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.enough_muons |->
            !result_reg.event_passed && result_reg.mass_band == BAND_LOW)
        else $error("failing event carries a pass or a band");

    a_enough: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            result_reg.enough_muons == (result_reg.muon_count >= CNT_W'(KEEP_COUNT)))
        else $error("enough flag disagrees with muon count");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |=> count_reg == '0 && state_reg == ST_IDLE)
        else $error("event state not cleared after result");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken while another is in flight");

endmodule

`default_nettype wire

// ===== tb/tb_top_four_muon_mass_band_filter.sv =====
// Testbench for top_four_muon_mass_band_filter: directed events, count saturation and
// randomized events over several register settings, checked against an in-bench predictor.
// Depends on fmmb_pkg and the filter RTL.
`default_nettype none

module tb_top_four_muon_mass_band_filter;

    import fmmb_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_ready;
    item_t              item_bus = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result_bus;

    logic [EN_W-1:0]    cfg_min_pt = 23'd1000;
    logic [ETA_W-1:0]   cfg_eta_sq = 24'd1409567;
    logic [EN_W-1:0]    cfg_mass_low = 23'd11000;
    logic [EN_W-1:0]    cfg_mass_high = 23'd25000;
    logic [PROB_W-1:0]  cfg_prob_low = 17'd65536;
    logic [PROB_W-1:0]  cfg_prob_mid = 17'd32768;
    logic [PROB_W-1:0]  cfg_prob_high = 17'd6554;
    logic               cfg_reweight = 1'b1;

    muon_t              kept_muons [KEEP_COUNT];
    int unsigned        muon_tally = 0;
    result_t            pending_verdicts [$];

    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        sent_count = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;

    top_four_muon_mass_band_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    task automatic clear_event;
        for (int i = 0; i < KEEP_COUNT; i++)
            kept_muons[i] = '0;
        muon_tally = 0;
    endtask

    task automatic absorb_particle(input item_t req);
        longint      px, py, pz, sx, sy, sz;
        logic [63:0] pt2, pz2, se, e2, p2;
        logic [79:0] pz_scaled, pt_scaled;
        logic [PROB_W-1:0] chance;
        int          held, pos;
        muon_t       fresh;
        result_t     verdict;
        band_t       band;
        if (req.particle_valid && req.is_muon && req.is_stable)
        begin
            px = $signed(req.mom_x);
            py = $signed(req.mom_y);
            pz = $signed(req.mom_z);
            pt2 = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py);
            pz2 = magnitude(pz) * magnitude(pz);
            pz_scaled = {8'd0, pz2, 8'd0};
            pt_scaled = 80'(pt2) * 80'(cfg_eta_sq);
            if (pt2 >= 64'(cfg_min_pt) * 64'(cfg_min_pt) && pz_scaled <= pt_scaled)
            begin
                fresh.px = req.mom_x;
                fresh.py = req.mom_y;
                fresh.pz = req.mom_z;
                fresh.energy = req.energy;
                fresh.pt2 = pt2[PT_W-1:0];
                held = (muon_tally < KEEP_COUNT) ? muon_tally : KEEP_COUNT;
                pos = 0;
                while (pos < held && kept_muons[pos].pt2 >= fresh.pt2)
                    pos++;
                if (muon_tally < 255)
                    muon_tally++;
                if (pos < KEEP_COUNT)
                begin
                    for (int i = (held < KEEP_COUNT) ? held : KEEP_COUNT - 1; i > pos; i--)
                        kept_muons[i] = kept_muons[i - 1];
                    kept_muons[pos] = fresh;
                end
            end
        end
        if (!req.last_particle)
            return;
        verdict = '0;
        verdict.muon_count = muon_tally[CNT_W-1:0];
        verdict.mass_band = BAND_LOW;
        if (muon_tally >= KEEP_COUNT)
        begin
            sx = 0;
            sy = 0;
            sz = 0;
            se = 0;
            for (int i = 0; i < KEEP_COUNT; i++)
            begin
                sx += $signed(kept_muons[i].px);
                sy += $signed(kept_muons[i].py);
                sz += $signed(kept_muons[i].pz);
                se += kept_muons[i].energy;
            end
            e2 = se * se;
            p2 = magnitude(sx) * magnitude(sx) + magnitude(sy) * magnitude(sy)
                 + magnitude(sz) * magnitude(sz);
            if (e2 < p2 + 64'(cfg_mass_low) * 64'(cfg_mass_low))
                band = BAND_LOW;
            else if (e2 > p2 + 64'(cfg_mass_high) * 64'(cfg_mass_high))
                band = BAND_HIGH;
            else
                band = BAND_MID;
            chance = (band == BAND_LOW) ? cfg_prob_low
                   : (band == BAND_MID) ? cfg_prob_mid : cfg_prob_high;
            verdict.enough_muons = 1'b1;
            verdict.mass_band = band;
            verdict.event_passed = !cfg_reweight || ({1'b0, req.random_draw} < chance);
        end
        pending_verdicts.insert(pending_verdicts.size(), verdict);
        clear_event();
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [DATA_W-1:0] word);
        case (idx)
            REG_MIN_PT:       cfg_min_pt = word[EN_W-1:0];
            REG_ETA_LIMIT_SQ: cfg_eta_sq = word[ETA_W-1:0];
            REG_MASS_LOW:     cfg_mass_low = word[EN_W-1:0];
            REG_MASS_HIGH:    cfg_mass_high = word[EN_W-1:0];
            REG_PROB_LOW:     cfg_prob_low = word[PROB_W-1:0];
            REG_PROB_MID:     cfg_prob_mid = word[PROB_W-1:0];
            REG_PROB_HIGH:    cfg_prob_high = word[PROB_W-1:0];
            REG_REWEIGHT_EN:  cfg_reweight = word[0];
            default:          ;
        endcase
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value,
                             input int unsigned width);
        logic [DATA_W-1:0] word;
        word = value;
        if ($urandom_range(1) != 0)
            word = word | (DATA_W'($urandom) << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        set_register(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_filter(input logic [DATA_W-1:0] min_pt, eta_sq, mass_low,
                                  mass_high, prob_low, prob_mid, prob_high, reweight);
        write_reg(REG_MIN_PT, min_pt, EN_W);
        write_reg(REG_ETA_LIMIT_SQ, eta_sq, ETA_W);
        write_reg(REG_MASS_LOW, mass_low, EN_W);
        write_reg(REG_MASS_HIGH, mass_high, EN_W);
        write_reg(REG_PROB_LOW, prob_low, PROB_W);
        write_reg(REG_PROB_MID, prob_mid, PROB_W);
        write_reg(REG_PROB_HIGH, prob_high, PROB_W);
        write_reg(REG_REWEIGHT_EN, reweight, 1);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic send_request(input item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= req;
        do
            @(posedge clk);
        while (!item_ready);
        absorb_particle(req);
        sent_count++;
    endtask

    task automatic wait_drained;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic settle_block;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [MOM_W-1:0] random_mom(input int unsigned bits);
        int unsigned b;
        b = (bits > MOM_W) ? MOM_W : bits;
        return MOM_W'($signed($urandom) >>> (32 - b));
    endfunction

    function automatic item_t fresh_particle(input int unsigned mom_bits);
        item_t       req;
        int unsigned e_bits;
        e_bits = (mom_bits + 2 > EN_W) ? EN_W : mom_bits + 2;
        req.particle_valid = 1'b1;
        req.is_muon        = 1'b1;
        req.is_stable      = 1'b1;
        req.mom_x          = random_mom(mom_bits);
        req.mom_y          = random_mom(mom_bits);
        req.mom_z          = random_mom(($urandom_range(3) == 0) ? mom_bits + 8 : mom_bits);
        req.energy         = EN_W'($urandom >> (32 - e_bits));
        req.last_particle  = 1'b0;
        req.random_draw    = RAND_W'($urandom);
        return req;
    endfunction

    function automatic item_t muon(input int px, input int py, input int pz,
                                   input int unsigned energy);
        item_t req;
        req = fresh_particle(16);
        req.mom_x  = MOM_W'(px);
        req.mom_y  = MOM_W'(py);
        req.mom_z  = MOM_W'(pz);
        req.energy = EN_W'(energy);
        return req;
    endfunction

    task automatic send_event;
        int unsigned n, mom_bits;
        item_t       req;
        mom_bits = ($urandom_range(9) == 0) ? MOM_W : $urandom_range(11, 15);
        if ($urandom_range(15) == 0)
        begin
            req = fresh_particle(mom_bits);
            req.particle_valid = 1'b0;
            req.last_particle  = 1'b1;
            send_request(req);
            return;
        end
        n = $urandom_range(1, 8);
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                req = fresh_particle(mom_bits);
                req.particle_valid = 1'b0;
                send_request(req);
            end
            req = fresh_particle(mom_bits);
            if ($urandom_range(9) < 3)
                {req.particle_valid, req.is_muon, req.is_stable} = 3'($urandom);
            req.last_particle = (k == n - 1);
            send_request(req);
        end
    endtask

    task automatic test_event_framing;
        item_t req;
        set_idling(0, 0);
        req = muon(5000, 0, 0, 9000);
        req.particle_valid = 1'b0;
        send_request(req);
        req.last_particle = 1'b1;
        send_request(req);
        req = muon(4000, 0, 0, 5000);
        req.is_stable = 1'b0;
        send_request(req);
        req = muon(4000, 0, 0, 5000);
        req.is_muon = 1'b0;
        send_request(req);
        send_request(muon(999, 0, 0, 2000));
        send_request(muon(1000, 0, 0, 2000));
        req = muon(1000, 0, 8388607, 8388607);
        req.last_particle = 1'b1;
        send_request(req);
    endtask

    task automatic test_extreme_momenta;
        item_t req;
        send_request(muon(-8388608, -8388608, 0, 8388607));
        send_request(muon(8388607, 8388607, 8388607, 8388607));
        send_request(muon(-8388608, 8388607, -8388608, 0));
        req = muon(8388607, 0, 0, 8388607);
        req.random_draw = 16'hFFFF;
        req.last_particle = 1'b1;
        send_request(req);
    endtask

    task automatic test_equal_pt_order;
        item_t req;
        send_request(muon(3000, 4000, 0, 9000));
        send_request(muon(4000, 3000, 0, 7000));
        send_request(muon(-5000, 0, 0, 6000));
        send_request(muon(0, 5000, 0, 8000));
        send_request(muon(-3000, -4000, 0, 30000));
        req = muon(2000, 0, 0, 2500);
        req.random_draw = 16'h0000;
        req.last_particle = 1'b1;
        send_request(req);
    endtask

    task automatic test_mass_bands;
        item_t req;
        send_request(muon(2000, 0, 0, 5000));
        send_request(muon(-2000, 0, 0, 5000));
        send_request(muon(0, 2000, 0, 5000));
        req = muon(0, -2000, 0, 5000);
        req.random_draw = 16'hFFFF;
        req.last_particle = 1'b1;
        send_request(req);
        for (int i = 0; i < KEEP_COUNT - 1; i++)
            send_request(muon(5000, 0, 0, 0));
        req = muon(5000, 0, 0, 0);
        req.random_draw = 16'hFFFF;
        req.last_particle = 1'b1;
        send_request(req);
    endtask

    task automatic test_count_saturation;
        item_t req;
        set_idling(8, 8);
        for (int i = 0; i < 258; i++)
        begin
            req = fresh_particle(13);
            req.mom_x = MOM_W'($urandom_range(2000, 60000));
            req.mom_z = '0;
            req.last_particle = (i == 257);
            send_request(req);
        end
    endtask

    task automatic test_random_phases;
        int unsigned goal;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle_block();
            case (phase)
                0: program_filter(1000, 1409567, 11000, 25000, 65536, 32768, 6554, 1);
                1: program_filter(1000, 1409567, $urandom_range(20000),
                                  $urandom_range(20000, 60000), 65536, 32768, 6554, 0);
                2: program_filter(0, 24'hFF_FFFF, 0, 0, 0, 0, 0, 1);
                3: program_filter(23'h7F_FFFF, 0, 23'h7F_FFFF, 23'h7F_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
                default: program_filter($urandom_range(2500), $urandom_range(24'hFF_FFFF),
                                        $urandom_range(40000), $urandom_range(60000),
                                        $urandom_range(65536), $urandom_range(65536),
                                        $urandom_range(65536), $urandom_range(1));
            endcase
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(82, 0);
                2: set_idling(0, 82);
                default: set_idling(8, 8);
            endcase
            goal = sent_count + 195;
            while (sent_count < goal)
            begin
                send_event();
                if ($urandom_range(29) == 0)
                    wait_drained();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: passed=%0d enough=%0d band=%0d count=%0d",
                             result_bus.event_passed, result_bus.enough_muons,
                             result_bus.mass_band, result_bus.muon_count);
            end
            else if (result_bus.event_passed !== pending_verdicts[0].event_passed
                     || result_bus.enough_muons !== pending_verdicts[0].enough_muons
                     || result_bus.mass_band !== pending_verdicts[0].mass_band
                     || result_bus.muon_count !== pending_verdicts[0].muon_count)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             pending_verdicts[0].event_passed, pending_verdicts[0].enough_muons,
                             pending_verdicts[0].mass_band, pending_verdicts[0].muon_count,
                             result_bus.event_passed, result_bus.enough_muons,
                             result_bus.mass_band, result_bus.muon_count);
            end
            if (pending_verdicts.size() != 0)
                void'(pending_verdicts.pop_front());
        end
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top_four_muon_mass_band_filter: errors");
            $finish;
        end
    end

    initial
    begin
        clear_event();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_event_framing();
        test_extreme_momenta();
        test_equal_pt_order();
        test_mass_bands();
        test_count_saturation();
        test_random_phases();
        wait_drained();
        repeat (24) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top_four_muon_mass_band_filter: clean");
        else
            $display("tb_top_four_muon_mass_band_filter: errors");
        $finish;
    end

endmodule

`default_nettype wire
